FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion on clk, switched off while rst is high.
`define DSTA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("dsta assertion failed");

// Condition that must never hold outside reset.
`define DSTA_ASSERT_NEVER(lbl, cond) \
  `DSTA_ASSERT(lbl, !(cond))

`endif

FILE: hw/rtl/dsta_pkg.sv
// Types and codes of the sighting table with aging.
// No dependencies.
package dsta_pkg;

  localparam int unsigned MAC_W   = 48;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned HITS_W  = 16;
  localparam int unsigned TOTAL_W = 7;

  localparam logic [TOTAL_W-1:0] OUT_LIMIT = 7'd64;
  localparam logic [HITS_W-1:0]  HITS_MAX  = 16'hFFFF;

  // input function codes
  localparam logic [1:0] FUNC_SIGHT  = 2'd0;
  localparam logic [1:0] FUNC_PRUNE  = 2'd1;
  localparam logic [1:0] FUNC_REPORT = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_ENTRY  = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;
  localparam logic [1:0] KIND_PRUNED = 2'd3;

  // sighting status
  localparam logic [1:0] STAT_UPDATED  = 2'd0;
  localparam logic [1:0] STAT_INSERTED = 2'd1;
  localparam logic [1:0] STAT_DROPPED  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MIN_COUNT  = 2'd0;
  localparam logic [1:0] CFG_STALE_MS   = 2'd1;
  localparam logic [1:0] CFG_MAX_REPORT = 2'd2;

  localparam logic [15:0]       MIN_COUNT_RST  = 16'd2;
  localparam logic [TIME_W-1:0] STALE_MS_RST   = 32'd120000;
  localparam logic [6:0]        MAX_REPORT_RST = 7'd40;

  typedef struct packed {
    logic [MAC_W-1:0]  addr;
    logic [1:0]        sources;
    logic [7:0]        strength;
    logic [HITS_W-1:0] hits;
    logic [TIME_W-1:0] seen;
    logic [TIME_W-1:0] rtime;
  } entry_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         status;
    logic [MAC_W-1:0]   mac;
    logic [1:0]         sources;
    logic [7:0]         rssi;
    logic [HITS_W-1:0]  count;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } res_t;

endpackage

FILE: hw/rtl/dsta_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dsta_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/dsta_out_reg.sv
// Output register for result words, valid/ready toward the consumer.
// Depends on dsta_pkg.
module dsta_out_reg
  import dsta_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_word,
  output logic push_ready,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_word
);

  assign push_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_ready) begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      out_word <= push_word;
    end
  end

endmodule

FILE: hw/rtl/device_sighting_table_aging_top.sv
// Sighting table with aging. Entries (address, radios, signal strength, count,
// last-seen and last-reported times) sit in one RAM of TABLE_DEPTH words, kept in
// insertion order, and every operation streams through the live entries at one
// entry per cycle through the RAM read port. One word is taken at a time; the
// input is ready again once the last result word of the previous one is handed
// to the output register. A sighting stops at the first address match. A report
// makes one pass over the table per picked entry, until it reaches the report
// limit or a pass finds no further qualifying entry: each pick is a full pass
// looking for the next-lowest (report time, position) key above the last pick,
// and a final pass stamps every picked entry with the current time.
// Configuration writes are taken in any cycle (cfg_ready is tied high) and
// should only be issued while the block is idle. Unused func code 3 is taken
// and produces no result.
module device_sighting_table_aging_top
  import dsta_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  // input words
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          func,
  input  logic [MAC_W-1:0]    mac,
  input  logic                source,
  input  logic signed [7:0]   rssi,
  input  logic [TIME_W-1:0]   time_ms,
  // result words
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          kind,
  output logic [1:0]          status,
  output logic [MAC_W-1:0]    mac_res,
  output logic [1:0]          sources,
  output logic signed [7:0]   rssi_res,
  output logic [HITS_W-1:0]   count,
  output logic [TOTAL_W-1:0]  total_entries,
  output logic                last,
  // configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned IW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IW-1:0] DEPTH_I = IW'(TABLE_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SIGHT  = 6'b000010,
    S_PRUNE  = 6'b000100,
    S_RPASS  = 6'b001000,
    S_RSTAMP = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t state, ret;

  // config
  logic [15:0]       min_count;
  logic [TIME_W-1:0] stale_ms;
  logic [6:0]        max_report;
  logic [6:0]        lim;

  // table
  logic [IW-1:0] total;
  logic [IW-1:0] ri, pidx, wr;
  logic          pv;
  logic          issue, done;

  // latched input word
  logic [MAC_W-1:0]  op_mac;
  logic              op_src;
  logic [7:0]        op_rssi;
  logic [TIME_W-1:0] op_now;

  // report scan
  entry_t        best, pend;
  logic [IW-1:0] best_idx, pend_idx;
  logic          have_best, have_pend;
  logic [6:0]    npick, npick_next;

  // RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata, rdata;

  // per-entry decisions on the word coming out of the RAM
  logic hit, keep, qual, after_prev, better, stamp_hit;

  res_t res, push_word, res_empty;
  logic push_ready;
  res_t out_word;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign lim       = (max_report > OUT_LIMIT) ? OUT_LIMIT : max_report;

  assign done       = !pv && (ri >= total);
  assign hit        = pv && (rdata.addr == op_mac);
  assign keep       = (op_now - rdata.seen) <= stale_ms;
  assign qual       = rdata.hits >= min_count;
  assign after_prev = !have_pend || ({rdata.rtime, pidx} > {pend.rtime, pend_idx});
  assign better     = !have_best || ({rdata.rtime, pidx} < {best.rtime, best_idx});
  assign stamp_hit  = qual && ({rdata.rtime, pidx} <= {pend.rtime, pend_idx});
  assign npick_next = npick + 7'd1;

  // empty report word, used when the report limit is zero
  always_comb begin
    res_empty      = '0;
    res_empty.kind = KIND_EMPTY;
    res_empty.last = 1'b1;
  end

  dsta_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ri[AW-1:0]),
    .rdata(rdata)
  );

  // read issue and write-back
  always_comb begin
    issue     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = pidx[AW-1:0];
    ram_wdata = rdata;
    unique case (state)
      S_SIGHT: begin
        issue = (ri < total) && !hit;
        if (hit) begin
          ram_we             = 1'b1;
          ram_wdata.strength = op_rssi;
          ram_wdata.seen     = op_now;
          ram_wdata.sources  = rdata.sources | {op_src, !op_src};
          if (rdata.hits != HITS_MAX) begin
            ram_wdata.hits = rdata.hits + 16'd1;
          end
        end else if (done && (total < DEPTH_I)) begin
          // append at the tail
          ram_we             = 1'b1;
          ram_waddr          = total[AW-1:0];
          ram_wdata.addr     = op_mac;
          ram_wdata.sources  = {op_src, !op_src};
          ram_wdata.strength = op_rssi;
          ram_wdata.hits     = 16'd1;
          ram_wdata.seen     = op_now;
          ram_wdata.rtime    = '0;
        end
      end
      S_PRUNE: begin
        issue = ri < total;
        if (pv && keep) begin
          // compact: write index never passes read index
          ram_we    = 1'b1;
          ram_waddr = wr[AW-1:0];
        end
      end
      S_RPASS: begin
        issue = ri < total;
      end
      S_RSTAMP: begin
        issue = ri < total;
        if (pv && stamp_hit) begin
          ram_we          = 1'b1;
          ram_wdata.rtime = op_now;
        end
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= S_IDLE;
      total      <= '0;
      pv         <= 1'b0;
      min_count  <= MIN_COUNT_RST;
      stale_ms   <= STALE_MS_RST;
      max_report <= MAX_REPORT_RST;
      have_best  <= 1'b0;
      have_pend  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MIN_COUNT:  min_count  <= cfg_data[15:0];
          CFG_STALE_MS:   stale_ms   <= cfg_data;
          CFG_MAX_REPORT: max_report <= cfg_data[6:0];
          default: ;
        endcase
      end

      pv <= issue;
      if (issue) begin
        pidx <= ri;
        ri   <= ri + IW'(1);
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_mac    <= mac;
            op_src    <= source;
            op_rssi   <= rssi;
            op_now    <= time_ms;
            ri        <= '0;
            wr        <= '0;
            npick     <= '0;
            have_best <= 1'b0;
            have_pend <= 1'b0;
            unique case (func)
              FUNC_SIGHT: begin
                res   <= '0;
                state <= S_SIGHT;
              end
              FUNC_PRUNE: begin
                res   <= '0;
                state <= S_PRUNE;
              end
              FUNC_REPORT: begin
                if (lim == 7'd0) begin
                  res   <= res_empty;
                  ret   <= S_IDLE;
                  state <= S_EMIT;
                end else begin
                  res   <= '0;
                  state <= S_RPASS;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SIGHT: begin
          if (hit) begin
            res.kind   <= KIND_ACK;
            res.status <= STAT_UPDATED;
            res.last   <= 1'b1;
            ret        <= S_IDLE;
            state      <= S_EMIT;
          end else if (done) begin
            res.kind <= KIND_ACK;
            res.last <= 1'b1;
            if (total < DEPTH_I) begin
              total      <= total + IW'(1);
              res.status <= STAT_INSERTED;
            end else begin
              res.status <= STAT_DROPPED;
            end
            ret   <= S_IDLE;
            state <= S_EMIT;
          end
        end
        S_PRUNE: begin
          if (pv && keep) begin
            wr <= wr + IW'(1);
          end
          if (done) begin
            total    <= wr;
            res.kind <= KIND_PRUNED;
            res.last <= 1'b1;
            ret      <= S_IDLE;
            state    <= S_EMIT;
          end
        end
        S_RPASS: begin
          if (pv && qual && after_prev && better) begin
            best      <= rdata;
            best_idx  <= pidx;
            have_best <= 1'b1;
          end
          if (done) begin
            ri        <= '0;
            have_best <= 1'b0;
            if (have_best) begin
              // best becomes the pending pick; older pending goes out
              pend      <= best;
              pend_idx  <= best_idx;
              have_pend <= 1'b1;
              npick     <= npick_next;
              if (have_pend) begin
                res.kind    <= KIND_ENTRY;
                res.status  <= STAT_UPDATED;
                res.mac     <= pend.addr;
                res.sources <= pend.sources;
                res.rssi    <= pend.strength;
                res.count   <= pend.hits;
                res.last    <= 1'b0;
                ret         <= (npick_next >= lim) ? S_RSTAMP : S_RPASS;
                state       <= S_EMIT;
              end else begin
                state <= (npick_next >= lim) ? S_RSTAMP : S_RPASS;
              end
            end else if (have_pend) begin
              state <= S_RSTAMP;
            end else begin
              res.kind <= KIND_EMPTY;
              res.last <= 1'b1;
              ret      <= S_IDLE;
              state    <= S_EMIT;
            end
          end
        end
        S_RSTAMP: begin
          if (done) begin
            res.kind    <= KIND_ENTRY;
            res.status  <= STAT_UPDATED;
            res.mac     <= pend.addr;
            res.sources <= pend.sources;
            res.rssi    <= pend.strength;
            res.count   <= pend.hits;
            res.last    <= 1'b1;
            ret         <= S_IDLE;
            state       <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (push_ready) begin
            state <= ret;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // entry count is taken as it stands when the word goes out
  always_comb begin
    push_word       = res;
    push_word.total = TOTAL_W'(total);
  end

  dsta_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (state == S_EMIT),
    .push_word (push_word),
    .push_ready(push_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  assign kind          = out_word.kind;
  assign status        = out_word.status;
  assign mac_res       = out_word.mac;
  assign sources       = out_word.sources;
  assign rssi_res      = out_word.rssi;
  assign count         = out_word.count;
  assign total_entries = out_word.total;
  assign last          = out_word.last;

endmodule

FILE: hw/rtl/dsta_checker.sv
// Port-level checks on the sighting table, bound to the top level.
// Depends on dsta_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dsta_checker
  import dsta_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         kind,
  input logic [1:0]         status,
  input logic               last
);

  // an input word waiting for ready stays offered
  `DSTA_ASSERT(a_in_hold, (in_valid && !in_ready) |=> in_valid)
  // only report entries may be followed by more words of the same item
  `DSTA_ASSERT(a_single_last, (out_valid && kind != KIND_ENTRY) |-> last)
  // status is only used by sighting acks
  `DSTA_ASSERT(a_status_ack_only, (out_valid && kind != KIND_ACK) |-> status == STAT_UPDATED)
  // no status code past dropped
  `DSTA_ASSERT_NEVER(a_status_range, out_valid && status == 2'd3)
  // a stalled result holds
  `DSTA_ASSERT(a_out_hold, (out_valid && !out_ready) |=> out_valid && $stable(kind))

endmodule

bind device_sighting_table_aging_top dsta_checker u_dsta_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .kind     (kind),
  .status   (status),
  .last     (last)
);
